### design/wis_pkg.sv
// Shared types and constants for the weighted interleave sequencer.
package wis_pkg;

    localparam int NUM_SOURCES    = 4;
    localparam int WEIGHT_W       = 7;
    localparam int TOTAL_W        = WEIGHT_W + $clog2(NUM_SOURCES);
    localparam int SRC_W          = $clog2(NUM_SOURCES);
    localparam int SLOT_FIELD_W   = 5;
    localparam int SLOT_COUNT_DEF = 24;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        weight_t weight_3;
        weight_t weight_2;
        weight_t weight_1;
        weight_t weight_0;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot_index;
        logic [SRC_W-1:0]        source_index;
        logic                    last_slot;
    } out_word_t;

    typedef struct packed {
        weight_t [NUM_SOURCES-1:0] weights;
        logic [TOTAL_W-1:0]        total;
    } job_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

endpackage

### design/wis_front.sv
// Front end: accept weight words, sum them, drop all-zero words, queue jobs.
module wis_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  wis_pkg::in_word_t in_data,
    output logic            job_valid,
    input  logic            job_ready,
    output wis_pkg::job_t   job
);
    import wis_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    job_t              incoming;
    logic              accept;
    logic              keep;
    logic              take;

    always_comb
    begin
        incoming.weights[0] = in_data.weight_0;
        incoming.weights[1] = in_data.weight_1;
        incoming.weights[2] = in_data.weight_2;
        incoming.weights[3] = in_data.weight_3;
        incoming.total      = TOTAL_W'(in_data.weight_0) + TOTAL_W'(in_data.weight_1)
                            + TOTAL_W'(in_data.weight_2) + TOTAL_W'(in_data.weight_3);
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept    = push && !full;
    assign keep      = accept && (incoming.total != '0);
    assign job_valid = (count_reg != '0);
    assign take      = job_valid && job_ready;
    assign job       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = keep ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (keep && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !keep)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            mem_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

### design/wis_back.sv
// Back end: run the slot sequence of one job and queue the result words.
module wis_back #(
    parameter int SLOT_COUNT = wis_pkg::SLOT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  wis_pkg::job_t      job,
    output logic               empty,
    input  logic               pop,
    output wis_pkg::out_word_t out_data
);
    import wis_pkg::*;

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SCORE_W = TOTAL_W + $clog2(SLOT_COUNT + 1) + 1;

    seq_state_t                state_reg;
    seq_state_t                state_next;
    weight_t                   weights_reg [NUM_SOURCES];
    logic [TOTAL_W-1:0]        total_reg;
    logic signed [SCORE_W-1:0] score_reg [NUM_SOURCES];
    logic [SLOT_W-1:0]         slot_reg;
    logic signed [SCORE_W-1:0] best;
    logic                      found;
    logic [SRC_W-1:0]          winner;
    logic                      load;
    logic                      emit;
    logic                      last;
    logic [31:0]               slot_wide;
    out_word_t                 word;

    out_word_t                 ofifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         owr_reg;
    logic [QPTR_W-1:0]         owr_next;
    logic [QPTR_W-1:0]         ord_reg;
    logic [QPTR_W-1:0]         ord_next;
    logic [QCNT_W-1:0]         ocnt_reg;
    logic [QCNT_W-1:0]         ocnt_next;
    logic                      ofull;
    logic                      otake;

    // pick the largest score among live sources, lowest index on ties
    always_comb
    begin
        best   = '0;
        found  = 1'b0;
        winner = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if ((weights_reg[i] != '0) && (!found || (score_reg[i] > best)))
            begin
                best   = score_reg[i];
                winner = SRC_W'(i);
                found  = 1'b1;
            end
        end
    end

    assign last      = (slot_reg == SLOT_W'(SLOT_COUNT - 1));
    assign slot_wide = 32'(slot_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (!ofull && last)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                job_ready = 1'b1;
            end
            SEQ_RUN:
            begin
                emit = !ofull;
            end
            default:
            begin
                job_ready = 1'b0;
            end
        endcase
    end

    assign load = job_valid && job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // advance scores: every source gains its weight, the winner pays the total
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                weights_reg[i] <= job.weights[i];
                score_reg[i]   <= SCORE_W'(job.weights[i]);
            end
            total_reg <= job.total;
            slot_reg  <= '0;
        end
        else if (emit)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                if (winner == SRC_W'(i))
                begin
                    score_reg[i] <= score_reg[i] + SCORE_W'(weights_reg[i])
                                  - SCORE_W'(total_reg);
                end
                else
                begin
                    score_reg[i] <= score_reg[i] + SCORE_W'(weights_reg[i]);
                end
            end
            slot_reg <= slot_reg + 1'b1;
        end
    end

    always_comb
    begin
        word.slot_index   = slot_wide[SLOT_FIELD_W-1:0];
        word.source_index = winner;
        word.last_slot    = last;
    end

    assign ofull    = (ocnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (ocnt_reg == '0);
    assign otake    = pop && !empty;
    assign out_data = ofifo_reg[ord_reg];

    always_comb
    begin
        owr_next  = emit ? owr_reg + 1'b1 : owr_reg;
        ord_next  = otake ? ord_reg + 1'b1 : ord_reg;
        ocnt_next = ocnt_reg;
        if (emit && !otake)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (otake && !emit)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            owr_reg  <= owr_next;
            ord_reg  <= ord_next;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ofifo_reg[owr_reg] <= word;
        end
    end

endmodule

### design/weighted_interleave_sequencer.sv
// Each weight word with a nonzero total yields SLOT_COUNT result words, one per
// clock while the result side keeps up, once the job has been loaded; a new job
// is loaded in the cycle after the last slot of the previous one is produced.
// The rate is set by the slot sequencer, which scores all sources in parallel
// each slot and keeps running deficits instead of multiplying. Words whose
// weights are all zero are dropped at the input and yield no results. A two-deep
// job queue sits between input and sequencer and a two-deep result queue at
// the output.
module weighted_interleave_sequencer #(
    parameter int SLOT_COUNT = wis_pkg::SLOT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  wis_pkg::in_word_t  in_data,
    output logic               empty,
    input  logic               pop,
    output wis_pkg::out_word_t out_data
);
    import wis_pkg::*;

    logic job_valid;
    logic job_ready;
    job_t job;

    wis_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    wis_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

endmodule

### design/wis_checker.sv
// Port-level checks for the weighted interleave sequencer, with its bind.
module wis_checker #(
    parameter int SLOT_COUNT = wis_pkg::SLOT_COUNT_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input wis_pkg::out_word_t out_data
);
    import wis_pkg::*;

    localparam logic [SLOT_FIELD_W-1:0] LAST_IDX = SLOT_FIELD_W'(SLOT_COUNT - 1);
    localparam logic                    NARROW   = (SLOT_COUNT <= 32);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("result word changed while waiting");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && NARROW) |-> (out_data.slot_index <= LAST_IDX))
        else $error("slot index beyond sequence length");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && NARROW) |-> (out_data.last_slot == (out_data.slot_index == LAST_IDX)))
        else $error("last slot mark disagrees with slot index");

    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind weighted_interleave_sequencer wis_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
);
